@@ hdl/tpr_pkg.sv @@
// ----------------------------------------------------------------------------
// tpr_pkg
// Shared types and constants of the tile plane renderer: memory geometry,
// register indexes, field widths and the controller/datapath interface.
// ----------------------------------------------------------------------------
package tpr_pkg;

  localparam int ADDR_BITS = 16;

  localparam int COL_W  = 5;
  localparam int ROW_W  = 5;
  localparam int LINE_W = 3;
  localparam int PIX_W  = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int TDATA_IN_W = 40;

  // Upper bits of a 32-byte aligned tile base
  localparam int BASE_HI_W = 11;

  localparam logic [7:0]  RAM_CODE_START  = 8'hE0;
  localparam logic [15:0] RAM_AREA_OFFSET = 16'h0400;
  localparam logic [4:0]  FIRST_DRAWN_COL = 5'd2;
  localparam logic [4:0]  LAST_DRAWN_COL  = 5'd29;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_RENDER = 1'b1;

  localparam logic [1:0] PLANE_W1 = 2'd1;
  localparam logic [1:0] PLANE_W2 = 2'd2;
  localparam logic [1:0] PLANE_W4 = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VRAM_PAGE     = 2'd0,
    CFG_PATTERN_BANK  = 2'd1,
    CFG_FORCE_PATTERN = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ADDR_WRITE      = 2'd0,
    ADDR_MAP        = 2'd1,
    ADDR_PLANE_NEW  = 2'd2,
    ADDR_PLANE_HELD = 2'd3
  } addr_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD = 2'd0,
    ACC_LOAD = 2'd1,
    ACC_OR   = 2'd2
  } acc_op_e;

  typedef struct packed {
    logic       latch;
    logic       mem_we;
    logic       mem_re;
    addr_sel_e  addr_sel;
    logic [1:0] plane;
    logic       base_load;
    acc_op_e    acc_op;
    logic       out_load;
  } tpr_cmd_t;

  typedef struct packed {
    logic render;
    logic blank;
  } tpr_sts_t;

endpackage

@@ hdl/tpr_vram.sv @@
// ----------------------------------------------------------------------------
// tpr_vram
// Single-port video memory, one byte wide, with registered read data.
// ----------------------------------------------------------------------------
module tpr_vram
  import tpr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic                 re_i,
  input  logic [ADDR_BITS-1:0] addr_i,
  input  logic [7:0]           wdata_i,
  output logic [7:0]           rdata_o
);

  logic [7:0] mem [2**ADDR_BITS];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  // Hold the last read byte while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/tpr_datapath.sv @@
// ----------------------------------------------------------------------------
// tpr_datapath
// Configuration registers, address generation, plane accumulation and the
// output data register.
// ----------------------------------------------------------------------------
module tpr_datapath
  import tpr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [TDATA_IN_W-1:0] in_data_i,
  input  logic                  in_user_i,
  input  tpr_cmd_t              cmd_i,
  output tpr_sts_t              sts_o,
  output logic                  mem_we_o,
  output logic                  mem_re_o,
  output logic [ADDR_BITS-1:0]  mem_addr_o,
  output logic [7:0]            mem_wdata_o,
  input  logic [7:0]            mem_rdata_i,
  output logic [PIX_W-1:0]      out_data_o
);

  logic [7:0]           vram_page_q;
  logic                 pattern_bank_q;
  logic                 force_pattern_q;

  logic [15:0]          in_address;
  logic [7:0]           in_byte;
  logic [COL_W-1:0]     in_col;
  logic [ROW_W-1:0]     in_row;
  logic [LINE_W-1:0]    in_line;

  logic [LINE_W-1:0]    line_q;
  logic                 blank_q;
  logic [BASE_HI_W-1:0] base_hi_q;
  logic [PIX_W-1:0]     acc_q, acc_d;
  logic [PIX_W-1:0]     out_q;

  logic [15:0]          map_addr;
  logic [15:0]          ram_base;
  logic [15:0]          tile_base;
  logic [BASE_HI_W-1:0] base_hi;
  logic [15:0]          addr_full;

  function automatic logic [PIX_W-1:0] spread(input logic [7:0] bits, input int unsigned k);
    logic [PIX_W-1:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      r[3*i+k] = bits[i];
    end
    return r;
  endfunction

  assign in_address = in_data_i[15:0];
  assign in_byte    = in_data_i[23:16];
  assign in_col     = in_data_i[28:24];
  assign in_row     = in_data_i[33:29];
  assign in_line    = in_data_i[36:34];

  assign sts_o.render = (in_user_i == CMD_RENDER);
  assign sts_o.blank  = (in_col < FIRST_DRAWN_COL) || (in_col > LAST_DRAWN_COL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vram_page_q     <= '0;
      pattern_bank_q  <= 1'b0;
      force_pattern_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_VRAM_PAGE:     vram_page_q     <= cfg_data_i;
        CFG_PATTERN_BANK:  pattern_bank_q  <= cfg_data_i[0];
        CFG_FORCE_PATTERN: force_pattern_q <= cfg_data_i[0];
        default:           ;
      endcase
    end
  end

  assign map_addr = {vram_page_q, 8'h00} + {6'd0, in_row, in_col};
  assign ram_base = {vram_page_q, 8'h00} + RAM_AREA_OFFSET + {6'd0, mem_rdata_i[4:0], 5'd0};

  // Code arrives from the tile map read in the first plane cycle
  always_comb begin
    if (mem_rdata_i < RAM_CODE_START || force_pattern_q) begin
      tile_base = {2'b00, pattern_bank_q, mem_rdata_i, 5'd0};
    end else begin
      tile_base = ram_base;
    end
  end

  assign base_hi = tile_base[15:5];

  always_comb begin
    unique case (cmd_i.addr_sel)
      ADDR_WRITE:      addr_full = in_address;
      ADDR_MAP:        addr_full = map_addr;
      ADDR_PLANE_NEW:  addr_full = {base_hi, cmd_i.plane, line_q};
      ADDR_PLANE_HELD: addr_full = {base_hi_q, cmd_i.plane, line_q};
      default:         addr_full = in_address;
    endcase
  end

  assign mem_addr_o  = addr_full[ADDR_BITS-1:0];
  assign mem_we_o    = cmd_i.mem_we;
  assign mem_re_o    = cmd_i.mem_re;
  assign mem_wdata_o = in_byte;

  always_comb begin
    unique case (cmd_i.acc_op)
      ACC_HOLD: acc_d = acc_q;
      ACC_LOAD: acc_d = spread(mem_rdata_i, 0);
      ACC_OR:   acc_d = acc_q | spread(mem_rdata_i, 1);
      default:  acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      line_q  <= in_line;
      blank_q <= sts_o.blank;
    end
    if (cmd_i.base_load) begin
      base_hi_q <= base_hi;
    end
    acc_q <= acc_d;
    if (cmd_i.out_load) begin
      out_q <= blank_q ? '0 : (acc_q | spread(mem_rdata_i, 2));
    end
  end

  assign out_data_o = out_q;

endmodule

@@ hdl/tpr_ctrl.sv @@
// ----------------------------------------------------------------------------
// tpr_ctrl
// Sequencer for the tile code read and the three plane reads, and the
// handshake of both stream channels.
// ----------------------------------------------------------------------------
module tpr_ctrl
  import tpr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  tpr_sts_t sts_i,
  output tpr_cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_P1   = 3'd1;
  localparam logic [2:0] ST_P2   = 3'd2;
  localparam logic [2:0] ST_P3   = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;
  logic       in_xfer;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) || ((state_q == ST_DONE) && out_free);
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.addr_sel = ADDR_WRITE;
    cmd_o.acc_op   = ACC_HOLD;
    cmd_o.plane    = PLANE_W1;

    unique case (state_q)
      ST_IDLE: ;
      ST_P1: begin
        cmd_o.mem_re    = 1'b1;
        cmd_o.addr_sel  = ADDR_PLANE_NEW;
        cmd_o.plane     = PLANE_W1;
        cmd_o.base_load = 1'b1;
        state_d         = ST_P2;
      end
      ST_P2: begin
        cmd_o.mem_re   = 1'b1;
        cmd_o.addr_sel = ADDR_PLANE_HELD;
        cmd_o.plane    = PLANE_W2;
        cmd_o.acc_op   = ACC_LOAD;
        state_d        = ST_P3;
      end
      ST_P3: begin
        cmd_o.mem_re   = 1'b1;
        cmd_o.addr_sel = ADDR_PLANE_HELD;
        cmd_o.plane    = PLANE_W4;
        cmd_o.acc_op   = ACC_OR;
        state_d        = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // A new item enters from idle or from a done state that is unloading
    if (in_xfer) begin
      if (!sts_i.render) begin
        cmd_o.mem_we   = 1'b1;
        cmd_o.addr_sel = ADDR_WRITE;
        state_d        = ST_IDLE;
      end else if (sts_i.blank) begin
        cmd_o.latch = 1'b1;
        state_d     = ST_DONE;
      end else begin
        cmd_o.latch    = 1'b1;
        cmd_o.mem_re   = 1'b1;
        cmd_o.addr_sel = ADDR_MAP;
        state_d        = ST_P1;
      end
    end
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ hdl/tile_plane_renderer.sv @@
// ----------------------------------------------------------------------------
// tile_plane_renderer
// Tile map renderer with its own video memory: stores bytes and renders one
// line of a tile as eight 3-bit colour indices.
// ----------------------------------------------------------------------------
//  channel   | direction | transfer carries
//  s_axis    | in        | tuser: command; tdata: mem_address, mem_data,
//            |           |   tile_col, tile_row, pixel_line
//  m_axis    | out       | tdata: pixel_colors
//  cfg       | in        | cfg_index_i: register, cfg_data_i: value
//
//  A memory write stores one byte. A drawn render does a tile code read, then
//  three plane reads on the single memory port; a new transfer is accepted
//  only in idle or while done unloads. Blank columns skip the memory reads.
//  A stalled result holds in the output register while further writes are
//  accepted; a render finishing behind it waits. Reset clears the configuration
//  registers and control; memory contents are undefined until written.
// ----------------------------------------------------------------------------
module tile_plane_renderer
  import tpr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [15:0] mem_address, [23:16] mem_data, [28:24] tile_col,
  // [33:29] tile_row, [36:34] pixel_line, [39:37] zero
  input  logic [TDATA_IN_W-1:0] s_axis_tdata,
  // [0] command
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [23:0] pixel_colors
  output logic [PIX_W-1:0]      m_axis_tdata,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  tpr_cmd_t             cmd;
  tpr_sts_t             sts;
  logic                 mem_we;
  logic                 mem_re;
  logic [ADDR_BITS-1:0] mem_addr;
  logic [7:0]           mem_wdata;
  logic [7:0]           mem_rdata;

  assign cfg_ready_o = 1'b1;

  tpr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tpr_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .mem_we_o    (mem_we),
    .mem_re_o    (mem_re),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (mem_rdata),
    .out_data_o  (m_axis_tdata)
  );

  tpr_vram u_vram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

endmodule
